// ----- rtl/twpp_pkg.sv -----
package twpp_pkg;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_PIVOT_ZERO = 2'd1,
    STATUS_OVERFLOW   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_LOAD,
    S_EMIT,
    S_DRAIN
  } state_e;

  typedef struct packed {
    logic [7:0] value;
    logic       last_item;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_value;
    logic       out_last;
    status_e    status;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic issue;
    logic clear;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic issue_last;
  } dp_sts_t;

endpackage

// ----- rtl/twpp_in_if.sv -----
interface twpp_in_if;
  logic               valid;
  logic               ready;
  twpp_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/twpp_out_if.sv -----
interface twpp_out_if;
  logic                valid;
  logic                ready;
  twpp_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/three_way_pivot_partition.sv -----
// Three-way partition of a byte frame around its first element. Elements are
// taken one per cycle into a MAX_LEN-entry store: smaller ones from the bottom,
// larger ones from the top, pivot-equal ones only counted; elements past
// MAX_LEN are dropped and the frame is flagged as overflow (status 2). After
// the last element the input stalls while the frame is sent out: smaller
// elements in arrival order, the pivot once per equal element, larger
// elements newest first. After the last element is taken the controller moves
// to its emit state; each result is issued to the store's single registered
// read port and follows one per cycle while the sink is ready. A frame gives
// one result per accepted element (at most MAX_LEN) and keeps the input closed
// until its last result is taken. A zero pivot gives a single result: value 0,
// last set, status 1.
module three_way_pivot_partition #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  twpp_in_if.sink    in_i,
  twpp_out_if.source out_o
);

  twpp_pkg::dp_cmd_t cmd;
  twpp_pkg::dp_sts_t sts;

  twpp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.data.last_item),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  twpp_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_value_i   (in_i.data.value),
    .out_value_o  (out_o.data.out_value),
    .out_last_o   (out_o.data.out_last),
    .out_status_o (out_o.data.status)
  );

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input open while a result is pending");

  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.data.last_item) |=> !in_i.ready)
    else $error("input not stalled after frame end");

  a_fail_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.status == twpp_pkg::STATUS_PIVOT_ZERO)
      |-> out_o.data.out_last)
    else $error("zero pivot result not final");
`endif

endmodule

// ----- rtl/twpp_ram.sv -----
module twpp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/twpp_dp.sv -----
module twpp_dp #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  twpp_pkg::dp_cmd_t   cmd_i,
  output twpp_pkg::dp_sts_t   sts_o,
  input  logic [7:0]          in_value_i,
  output logic [7:0]          out_value_o,
  output logic                out_last_o,
  output twpp_pkg::status_e   out_status_o
);

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam logic [CW-1:0] MaxLenC = CW'(MAX_LEN);
  localparam logic [CW-1:0] TopIdx  = CW'(MAX_LEN - 1);

  logic [7:0]    pivot_q, pivot_d;
  logic [CW-1:0] less_q, less_d;
  logic [CW-1:0] greater_q, greater_d;
  logic [CW-1:0] total_q, total_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] k_q, k_d;

  logic              sel_pivot_q, sel_pivot_d;
  logic              out_last_q, out_last_d;
  twpp_pkg::status_e out_status_q, out_status_d;

  logic [7:0]    piv;
  logic          room, is_less, is_greater;
  logic [CW-1:0] top_slot;
  logic          we;
  logic [AW-1:0] waddr;

  logic          pivot_zero, in_less, sel_pivot;
  logic [CW-1:0] eq_end, upper_idx;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;

  // load side
  always_comb begin
    piv        = (total_q == '0) ? in_value_i : pivot_q;
    room       = total_q < MaxLenC;
    is_less    = in_value_i < piv;
    is_greater = in_value_i > piv;
    top_slot   = TopIdx - greater_q;
    we         = cmd_i.load && room && (is_less || is_greater);
    waddr      = is_less ? less_q[AW-1:0] : top_slot[AW-1:0];
  end

  // emission side
  always_comb begin
    pivot_zero = pivot_q == 8'd0;
    eq_end     = total_q - greater_q;
    in_less    = k_q < less_q;
    sel_pivot  = pivot_zero || (!in_less && (k_q < eq_end));
    upper_idx  = MaxLenC - total_q + k_q;
    raddr      = in_less ? k_q[AW-1:0] : upper_idx[AW-1:0];
    sts_o.issue_last = pivot_zero || (k_q == total_q - CW'(1));
  end

  always_comb begin
    pivot_d      = pivot_q;
    less_d       = less_q;
    greater_d    = greater_q;
    total_d      = total_q;
    ovf_d        = ovf_q;
    k_d          = k_q;
    sel_pivot_d  = sel_pivot_q;
    out_last_d   = out_last_q;
    out_status_d = out_status_q;
    if (cmd_i.load) begin
      pivot_d = piv;
      if (room) begin
        total_d = total_q + CW'(1);
        if (is_less) begin
          less_d = less_q + CW'(1);
        end else if (is_greater) begin
          greater_d = greater_q + CW'(1);
        end
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (cmd_i.issue) begin
      k_d          = k_q + CW'(1);
      sel_pivot_d  = sel_pivot;
      out_last_d   = sts_o.issue_last;
      out_status_d = pivot_zero ? twpp_pkg::STATUS_PIVOT_ZERO :
                     ovf_q      ? twpp_pkg::STATUS_OVERFLOW   : twpp_pkg::STATUS_OK;
    end
    if (cmd_i.clear) begin
      pivot_d   = '0;
      less_d    = '0;
      greater_d = '0;
      total_d   = '0;
      ovf_d     = 1'b0;
      k_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pivot_q   <= '0;
      less_q    <= '0;
      greater_q <= '0;
      total_q   <= '0;
      ovf_q     <= 1'b0;
      k_q       <= '0;
    end else begin
      pivot_q   <= pivot_d;
      less_q    <= less_d;
      greater_q <= greater_d;
      total_q   <= total_d;
      ovf_q     <= ovf_d;
      k_q       <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_pivot_q  <= sel_pivot_d;
    out_last_q   <= out_last_d;
    out_status_q <= out_status_d;
  end

  twpp_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LEN)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (in_value_i),
    .re_i    (cmd_i.issue),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // read register holds while the result waits, so the mux stays stable
  assign out_value_o  = sel_pivot_q ? pivot_q : rdata;
  assign out_last_o   = out_last_q;
  assign out_status_o = out_status_q;

endmodule

// ----- rtl/twpp_ctrl.sv -----
module twpp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output twpp_pkg::dp_cmd_t cmd_o,
  input  twpp_pkg::dp_sts_t sts_i
);

  twpp_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             in_fire, out_fire, issue;

  assign in_ready_o  = state_q == twpp_pkg::S_LOAD;
  assign out_valid_o = out_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_q && out_ready_i;
  assign issue       = (state_q == twpp_pkg::S_EMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      twpp_pkg::S_LOAD: begin
        if (in_fire && in_last_i) begin
          state_d = twpp_pkg::S_EMIT;
        end
      end
      twpp_pkg::S_EMIT: begin
        if (issue && sts_i.issue_last) begin
          state_d = twpp_pkg::S_DRAIN;
        end
      end
      twpp_pkg::S_DRAIN: begin
        if (out_fire) begin
          state_d = twpp_pkg::S_LOAD;
        end
      end
      default: state_d = twpp_pkg::S_LOAD;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    out_valid_d = out_valid_q;
    unique case (state_q)
      twpp_pkg::S_LOAD: begin
        cmd_o.load = in_fire;
      end
      twpp_pkg::S_EMIT: begin
        cmd_o.issue = issue;
        if (issue) begin
          out_valid_d = 1'b1;
        end
      end
      twpp_pkg::S_DRAIN: begin
        if (out_fire) begin
          cmd_o.clear = 1'b1;
          out_valid_d = 1'b0;
        end
      end
      default: out_valid_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= twpp_pkg::S_LOAD;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned FRAME_CAP = 64;

  logic clk_i;
  logic rst_ni;

  twpp_in_if  in_ch ();
  twpp_out_if out_ch ();

  three_way_pivot_partition #(
    .MAX_LEN(FRAME_CAP)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // request stream and predicted partition output
  twpp_pkg::in_item_t  element_q[$];
  twpp_pkg::out_item_t partitioned_q[$];

  // predictor state
  logic [7:0]  part_store[FRAME_CAP];
  logic [7:0]  pivot_q;
  int unsigned less_n;
  int unsigned greater_n;
  int unsigned total_n;
  bit          overflow_seen;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_req;
  int unsigned hold_left;

  int unsigned errors;
  int unsigned frames_done;
  int unsigned zero_frames;
  int unsigned overflow_frames;
  int unsigned results_seen;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni       = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

  task automatic push_result(logic [7:0] v, twpp_pkg::status_e st);
    twpp_pkg::out_item_t r;
    r.out_value = v;
    r.out_last  = 1'b0;
    r.status    = st;
    partitioned_q.push_back(r);
  endtask

  task automatic partition_element(twpp_pkg::in_item_t it);
    int unsigned         eq_n;
    int unsigned         i;
    twpp_pkg::status_e   st;
    twpp_pkg::out_item_t r;
    if (total_n == 0) pivot_q = it.value;
    if (total_n < FRAME_CAP) begin
      if (it.value < pivot_q) begin
        part_store[less_n] = it.value;
        less_n++;
      end else if (it.value > pivot_q) begin
        part_store[FRAME_CAP - 1 - greater_n] = it.value;
        greater_n++;
      end
      total_n++;
    end else begin
      overflow_seen = 1'b1;
    end
    if (it.last_item) begin
      frames_done++;
      if (pivot_q == 8'd0) begin
        zero_frames++;
        r.out_value = 8'd0;
        r.out_last  = 1'b1;
        r.status    = twpp_pkg::STATUS_PIVOT_ZERO;
        partitioned_q.push_back(r);
      end else begin
        if (overflow_seen) overflow_frames++;
        st   = overflow_seen ? twpp_pkg::STATUS_OVERFLOW : twpp_pkg::STATUS_OK;
        eq_n = total_n - less_n - greater_n;
        for (i = 0; i < less_n; i++) push_result(part_store[i], st);
        for (i = 0; i < eq_n; i++) push_result(pivot_q, st);
        for (i = FRAME_CAP - greater_n; i < FRAME_CAP; i++) push_result(part_store[i], st);
        partitioned_q[partitioned_q.size() - 1].out_last = 1'b1;
      end
      pivot_q       = 8'd0;
      less_n        = 0;
      greater_n     = 0;
      total_n       = 0;
      overflow_seen = 1'b0;
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) partition_element(in_ch.data);
      if (!in_ch.valid || in_ch.ready) begin
        if (element_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.data  <= element_q.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (partitioned_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result value=%0d last=%0b status=%0d", $realtime,
                   out_ch.data.out_value, out_ch.data.out_last, out_ch.data.status);
        end else begin
          if (out_ch.data.out_value !== partitioned_q[0].out_value) begin
            errors++;
            $display("%0t: out_value expected %0d actual %0d", $realtime,
                     partitioned_q[0].out_value, out_ch.data.out_value);
          end
          if (out_ch.data.out_last !== partitioned_q[0].out_last) begin
            errors++;
            $display("%0t: out_last expected %0b actual %0b", $realtime,
                     partitioned_q[0].out_last, out_ch.data.out_last);
          end
          if (out_ch.data.status !== partitioned_q[0].status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $realtime,
                     partitioned_q[0].status, out_ch.data.status);
          end
          void'(partitioned_q.pop_front());
        end
      end
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic push_elem(logic [7:0] v, logic last);
    twpp_pkg::in_item_t it;
    it.value     = v;
    it.last_item = last;
    element_q.push_back(it);
  endtask

  task automatic push_random_frame(int unsigned len, bit zero_pivot);
    logic [7:0]  piv;
    logic [7:0]  v;
    int unsigned k;
    piv = zero_pivot ? 8'd0 : 8'($urandom_range(1, 255));
    push_elem(piv, len == 1);
    for (k = 1; k < len; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: v = 8'($urandom_range(0, 255));
        5, 6, 7:       v = piv + 8'($urandom_range(0, 4)) - 8'd2;
        default:       v = piv;
      endcase
      push_elem(v, k == len - 1);
    end
  endtask

  task automatic push_random_frames(int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      push_random_frame(len, $urandom_range(0, 9) == 0);
      sent += len;
    end
  endtask

  task automatic wait_frames_out();
    do @(negedge clk_i);
    while (element_q.size() != 0 || in_ch.valid || partitioned_q.size() != 0);
  endtask

  initial begin
    send_idle_pct   = 33;
    recv_idle_pct   = 48;
    hold_req        = 0;
    hold_left       = 0;
    errors          = 0;
    frames_done     = 0;
    zero_frames     = 0;
    overflow_frames = 0;
    results_seen    = 0;
    pivot_q         = 8'd0;
    less_n          = 0;
    greater_n       = 0;
    total_n         = 0;
    overflow_seen   = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);

    // single-element frames (pivot 255 and 0), then a three-element zero-pivot frame
    push_elem(8'd255, 1'b1);
    push_elem(8'd0, 1'b1);
    push_elem(8'd0, 1'b0);
    push_elem(8'd5, 1'b0);
    push_elem(8'd255, 1'b1);
    // smaller, equal and larger mixed
    push_elem(8'd128, 1'b0);
    push_elem(8'd0, 1'b0);
    push_elem(8'd255, 1'b0);
    push_elem(8'd128, 1'b0);
    push_elem(8'd1, 1'b0);
    push_elem(8'd254, 1'b1);
    push_elem(8'd1, 1'b0);
    push_elem(8'd0, 1'b0);
    push_elem(8'd0, 1'b0);
    push_elem(8'd1, 1'b0);
    push_elem(8'd255, 1'b1);
    push_elem(8'd255, 1'b0);
    push_elem(8'd0, 1'b0);
    push_elem(8'd255, 1'b0);
    push_elem(8'd254, 1'b1);
    push_elem(8'd77, 1'b0);
    push_elem(8'd77, 1'b0);
    push_elem(8'd77, 1'b1);
    wait_frames_out();

    // long sink stall with the source still offering
    hold_req = 300;
    push_random_frame(12, 1'b0);
    push_random_frame(4, 1'b0);
    wait_frames_out();

    send_idle_pct = 48;
    recv_idle_pct = 33;
    push_random_frames(8);
    wait_frames_out();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // capacity boundary with the last element dropped
    push_random_frame(FRAME_CAP + 1, 1'b0);
    wait_frames_out();
    repeat (2 * FRAME_CAP + 20) @(negedge clk_i);

    $display("Frames: %0d (%0d zero pivot, %0d overflow), results checked: %0d",
             frames_done, zero_frames, overflow_frames, results_seen);
    $display("Idle mixes 33/48, 48/33 and none, plus a long sink stall; mismatches: %0d",
             errors);
    if (errors == 0 && partitioned_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
